// ===== design/opi_pkg.sv =====
// shared types, codes and default constants for the ofdm pilot insertion block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package opi_pkg;

    localparam int WORD_W = 64;

    // defaults for the top-level parameters
    localparam int FFT_SIZE_DEF        = 64;
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int SAMPLE_INT_BITS_DEF = 2;
    localparam int PARAM_ID_BITS_DEF   = 8;
    localparam int PARAM_VAL_BITS_DEF  = 32;

    // parameter words addressed to this block
    localparam int MODULE_SELF = 3;
    localparam int PID_LEN     = 0;
    localparam int PID_SYM     = 1;
    localparam int PID_SPC     = 2;

    // word classes from the front
    localparam logic [1:0] KIND_PASS  = 2'd0;
    localparam logic [1:0] KIND_PARAM = 2'd1;
    localparam logic [1:0] KIND_TERM  = 2'd2;

    // parameter targets
    localparam logic [1:0] PSEL_NONE = 2'd0;
    localparam logic [1:0] PSEL_LEN  = 2'd1;
    localparam logic [1:0] PSEL_SYM  = 2'd2;
    localparam logic [1:0] PSEL_SPC  = 2'd3;

    // normalization divisor is q4.12
    localparam int NORM_FRAC = 12;

    // configuration registers
    localparam int         CFG_ADDR_W   = 4;
    localparam int         CFG_DATA_W   = 32;
    localparam logic [1:0] REG_PILOT_RE = 2'd0;
    localparam logic [1:0] REG_PILOT_IM = 2'd1;
    localparam logic [1:0] REG_NORM     = 2'd2;

    localparam logic [1:0]  PILOT_RE_RST = 2'd1;
    localparam logic [1:0]  PILOT_IM_RST = 2'd0;
    localparam logic [15:0] NORM_RST     = 16'd12953;

    localparam int QUEUE_DEPTH = 2;

    // shared bit-serial divider
    localparam int DIV_DVD_W = 64;
    localparam int DIV_DVS_W = 32;
    localparam int DIV_CNT_W = 7;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        psel;
        logic [31:0]       pval;
        logic [WORD_W-1:0] word;
    } opi_cmd_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] steps;
    } opi_div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } opi_div_rsp_t;

endpackage

`default_nettype wire

// ===== design/ofdm_pilot_insertion_top.sv =====
// top level: apb register file, front, command queue, back and shared divider
// depends on opi_pkg, opi_front, opi_queue, opi_divider, opi_back
//
// channel   direction  handshake          payload
// input     in         in_valid/in_stall  in_word[63:0]
// output    out        out_valid/out_stall out_word[63:0], last_of_run
// config    in/out     apb psel/penable   paddr[3:0], pwdata/prdata[31:0]
//
// a forwarded word goes from the queue via the emit register to the output register
// a sample with a nonzero divisor runs the bit-serial divider twice, once per part;
// a terminating word with spacing of two or more also runs it twice
// each pilot adds one output word; parameter words for this block give no output
// rst_n clears control state at once, no clearing pass
// the queue accepts until full while the back waits on a stalled output register
`timescale 1ns / 1ps
`default_nettype none

module ofdm_pilot_insertion_top
    import opi_pkg::*;
#(
    parameter int FFT_SIZE        = FFT_SIZE_DEF,
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int SAMPLE_INT_BITS = SAMPLE_INT_BITS_DEF,
    parameter int PARAM_ID_BITS   = PARAM_ID_BITS_DEF,
    parameter int PARAM_VAL_BITS  = PARAM_VAL_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [WORD_W-1:0]     in_word,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [WORD_W-1:0]     out_word,
    output logic                       last_of_run
);

    logic [1:0]   pilot_re_reg;
    logic [1:0]   pilot_im_reg;
    logic [15:0]  norm_reg;
    logic         cfg_wr;
    logic [1:0]   cfg_idx;

    logic         q_push, q_full, q_pop, q_valid;
    opi_cmd_t     push_cmd, head_cmd;
    opi_div_req_t div_req;
    opi_div_rsp_t div_rsp;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pilot_re_reg <= PILOT_RE_RST;
            pilot_im_reg <= PILOT_IM_RST;
            norm_reg     <= NORM_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PILOT_RE: pilot_re_reg <= pwdata[1:0];
                REG_PILOT_IM: pilot_im_reg <= pwdata[1:0];
                REG_NORM:     norm_reg     <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PILOT_RE: prdata = CFG_DATA_W'(pilot_re_reg);
            REG_PILOT_IM: prdata = CFG_DATA_W'(pilot_im_reg);
            REG_NORM:     prdata = CFG_DATA_W'(norm_reg);
            default:      prdata = '0;
        endcase
    end

    opi_front #(
        .PARAM_ID_BITS  (PARAM_ID_BITS),
        .PARAM_VAL_BITS (PARAM_VAL_BITS)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    opi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (head_cmd)
    );

    opi_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    opi_back #(
        .FFT_SIZE        (FFT_SIZE),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .SAMPLE_INT_BITS (SAMPLE_INT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (head_cmd),
        .q_pop       (q_pop),
        .pilot_re    (pilot_re_reg),
        .pilot_im    (pilot_im_reg),
        .norm_div    (norm_reg),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_word    (out_word),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ===== design/opi_front.sv =====
// front: accepts input words and classifies them for the back
// depends on opi_pkg
`timescale 1ns / 1ps
`default_nettype none

module opi_front
    import opi_pkg::*;
#(
    parameter int PARAM_ID_BITS  = PARAM_ID_BITS_DEF,
    parameter int PARAM_VAL_BITS = PARAM_VAL_BITS_DEF
)
(
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [WORD_W-1:0] in_word,
    input  wire logic              q_full,
    output logic                   q_push,
    output opi_cmd_t               q_cmd
);

    localparam int MOD_SHIFT = PARAM_ID_BITS + PARAM_VAL_BITS;
    localparam int MOD_W     = WORD_W - MOD_SHIFT;

    logic [MOD_W-1:0]         mod_id;
    logic [PARAM_ID_BITS-1:0] par_id;

    assign mod_id   = in_word[WORD_W-1:MOD_SHIFT];
    assign par_id   = in_word[MOD_SHIFT-1:PARAM_VAL_BITS];
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_cmd.word = in_word;
        q_cmd.pval = 32'(in_word[PARAM_VAL_BITS-1:0]);

        if (mod_id == MOD_W'(MODULE_SELF))
            q_cmd.kind = KIND_PARAM;
        else if (&mod_id)
            q_cmd.kind = KIND_TERM;
        else
            q_cmd.kind = KIND_PASS;

        if (par_id == PARAM_ID_BITS'(PID_LEN))
            q_cmd.psel = PSEL_LEN;
        else if (par_id == PARAM_ID_BITS'(PID_SYM))
            q_cmd.psel = PSEL_SYM;
        else if (par_id == PARAM_ID_BITS'(PID_SPC))
            q_cmd.psel = PSEL_SPC;
        else
            q_cmd.psel = PSEL_NONE;
    end

endmodule

`default_nettype wire

// ===== design/opi_queue.sv =====
// short command queue between front and back
// depends on opi_pkg
`timescale 1ns / 1ps
`default_nettype none

module opi_queue
    import opi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire opi_cmd_t push_cmd,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output opi_cmd_t      head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    opi_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// ===== design/opi_divider.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on opi_pkg; the dividend is left-aligned, steps gives its significant bits
`timescale 1ns / 1ps
`default_nettype none

module opi_divider
    import opi_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire opi_div_req_t req,
    output opi_div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DVD_W-1:0] dvd_reg;
    logic [DIV_DVS_W-1:0] dvs_reg;
    logic [DIV_DVS_W-1:0] rem_reg;
    logic [DIV_DVD_W-1:0] quo_reg;

    logic [DIV_DVS_W:0]   rem_sh;
    logic [DIV_DVS_W:0]   rem_sub;
    logic                 ge;
    logic                 load;

    assign load    = req.start && !busy_reg;
    assign rem_sh  = {rem_reg, dvd_reg[DIV_DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign ge      = rem_sh >= {1'b0, dvs_reg};

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != DIV_CNT_W'(1);
            done_reg <= cnt_reg == DIV_CNT_W'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_DVD_W-2:0], 1'b0};
            rem_reg <= ge ? rem_sub[DIV_DVS_W-1:0] : rem_sh[DIV_DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_DVD_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ===== design/opi_back.sv =====
// back: phase control, symbol and slot counters, normalization, pilots, output register
// depends on opi_pkg; drives the shared divider
`timescale 1ns / 1ps
`default_nettype none

module opi_back
    import opi_pkg::*;
#(
    parameter int FFT_SIZE        = FFT_SIZE_DEF,
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int SAMPLE_INT_BITS = SAMPLE_INT_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire opi_cmd_t          q_head,
    output logic                   q_pop,
    input  wire logic [1:0]        pilot_re,
    input  wire logic [1:0]        pilot_im,
    input  wire logic [15:0]       norm_div,
    output opi_div_req_t           div_req,
    input  wire opi_div_rsp_t      div_rsp,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [WORD_W-1:0]      out_word,
    output logic                   last_of_run
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int IB     = SAMPLE_INT_BITS;
    localparam int SLOT_W = $clog2(FFT_SIZE);
    localparam int FFT_W  = $clog2(FFT_SIZE + 1);
    localparam int MAG_W  = SW + NORM_FRAC;
    localparam int FRAC_W = (SW > IB) ? (SW - IB) : 0;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_PILOT = 3'd4;

    localparam logic [1:0] JOB_DEN = 2'd0;
    localparam logic [1:0] JOB_TOT = 2'd1;
    localparam logic [1:0] JOB_RE  = 2'd2;
    localparam logic [1:0] JOB_IM  = 2'd3;

    logic [2:0]        st_reg, st_next;
    logic [1:0]        job_reg, job_next;
    logic              phase_reg, phase_next;
    logic [31:0]       len_reg, len_next;
    logic [31:0]       nsym_reg, nsym_next;
    logic [31:0]       spc_reg, spc_next;
    logic [31:0]       total_reg, total_next;
    logic [31:0]       sym_reg, sym_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] pcnt_reg, pcnt_next;
    logic              emit_adv_reg, emit_adv_next;
    logic              pilot_cnt_reg, pilot_cnt_next;
    logic              out_valid_reg, out_valid_next;

    logic [FFT_W-1:0]  denom_reg, denom_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [WORD_W-1:0] emit_word_reg, emit_word_next;
    logic [SW-1:0]     re_q_reg, re_q_next;
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    logic              out_last_reg, out_last_next;

    // slot advance
    logic              wrap;
    logic [SLOT_W-1:0] slot_adv, pcnt_adv;
    logic [31:0]       sym_adv;
    logic              phase_adv;
    logic              do_adv;
    logic [SLOT_W-1:0] slot_aft, pcnt_aft;
    logic [31:0]       sym_aft;
    logic              phase_aft;
    logic              more;
    logic              emit_ok;

    // sample and pilot datapath
    logic [SW-1:0]     re_bits, im_bits, re_mag, im_mag;
    logic [SW-1:0]     q_lo, q_signed;
    logic              q_neg;
    logic [31:0]       tot_sat;
    logic [63:0]       prod;
    logic signed [1:0] pr_s, pi_s;
    logic [IB-1:0]     pint_re, pint_im;
    logic [SW+IB-1:0]  pre_ext, pim_ext;
    logic [WORD_W-1:0] pilot_word;

    assign emit_ok = !out_valid_reg || !out_stall;

    assign wrap      = slot_reg == SLOT_W'(FFT_SIZE - 1);
    assign slot_adv  = wrap ? '0 : slot_reg + 1'b1;
    assign pcnt_adv  = (wrap || (32'(pcnt_reg) + 32'd1 == spc_reg)) ? '0 : pcnt_reg + 1'b1;
    assign sym_adv   = wrap ? sym_reg + 32'd1 : sym_reg;
    assign phase_adv = wrap ? (sym_reg + 32'd1 < total_reg) : phase_reg;

    assign do_adv    = (st_reg == ST_PILOT) || emit_adv_reg;
    assign slot_aft  = do_adv ? slot_adv : slot_reg;
    assign pcnt_aft  = do_adv ? pcnt_adv : pcnt_reg;
    assign sym_aft   = do_adv ? sym_adv : sym_reg;
    assign phase_aft = do_adv ? phase_adv : phase_reg;
    // another pilot follows while at most three words come from one transaction
    assign more = phase_aft && (pcnt_aft == '0) && ((st_reg == ST_EMIT) || !pilot_cnt_reg);

    assign re_bits = q_head.word[32 +: SW];
    assign im_bits = word_reg[0 +: SW];
    assign re_mag  = re_bits[SW-1] ? (~re_bits + 1'b1) : re_bits;
    assign im_mag  = im_bits[SW-1] ? (~im_bits + 1'b1) : im_bits;

    assign q_neg    = (job_reg == JOB_RE) ? word_reg[32 + SW - 1] : word_reg[SW - 1];
    assign q_lo     = div_rsp.quotient[SW-1:0];
    assign q_signed = q_neg ? (~q_lo + 1'b1) : q_lo;

    assign tot_sat = (|div_rsp.quotient[63:32]) ? 32'hFFFF_FFFF : div_rsp.quotient[31:0];
    assign prod    = len_reg * nsym_reg;

    assign pr_s       = pilot_re;
    assign pi_s       = pilot_im;
    assign pint_re    = IB'(pr_s);
    assign pint_im    = IB'(pi_s);
    assign pre_ext    = (SW+IB)'(pint_re) << FRAC_W;
    assign pim_ext    = (SW+IB)'(pint_im) << FRAC_W;
    assign pilot_word = (WORD_W'(pre_ext[SW-1:0]) << 32) | WORD_W'(pim_ext[SW-1:0]);

    always_comb
    begin
        st_next        = st_reg;
        job_next       = job_reg;
        phase_next     = phase_reg;
        len_next       = len_reg;
        nsym_next      = nsym_reg;
        spc_next       = spc_reg;
        total_next     = total_reg;
        sym_next       = sym_reg;
        slot_next      = slot_reg;
        pcnt_next      = pcnt_reg;
        emit_adv_next  = emit_adv_reg;
        pilot_cnt_next = pilot_cnt_reg;
        out_valid_next = out_valid_reg;
        denom_next     = denom_reg;
        word_next      = word_reg;
        emit_word_next = emit_word_reg;
        re_q_next      = re_q_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        div_req        = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    word_next = q_head.word;
                    if (phase_reg)
                    begin
                        emit_adv_next = 1'b1;
                        if (norm_div == '0)
                        begin
                            emit_word_next = '0;
                            st_next        = ST_EMIT;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DIV_DVD_W'({re_mag, NORM_FRAC'(0)})
                                               << (DIV_DVD_W - MAG_W);
                            div_req.divisor  = DIV_DVS_W'(norm_div);
                            div_req.steps    = DIV_CNT_W'(MAG_W);
                            job_next         = JOB_RE;
                            st_next          = ST_DIV;
                        end
                    end
                    else
                    begin
                        case (q_head.kind)
                            KIND_PARAM:
                            begin
                                case (q_head.psel)
                                    PSEL_LEN: len_next  = q_head.pval;
                                    PSEL_SYM: nsym_next = q_head.pval;
                                    PSEL_SPC: spc_next  = q_head.pval;
                                    default:  ;
                                endcase
                            end
                            KIND_PASS:
                            begin
                                emit_word_next = q_head.word;
                                emit_adv_next  = 1'b0;
                                st_next        = ST_EMIT;
                            end
                            KIND_TERM:
                            begin
                                emit_word_next = q_head.word;
                                emit_adv_next  = 1'b0;
                                total_next     = '0;
                                sym_next       = '0;
                                slot_next      = '0;
                                pcnt_next      = '0;
                                if (spc_reg < 32'd2)
                                begin
                                    st_next = ST_EMIT;
                                end
                                else
                                begin
                                    // fft_size / spacing first, for the data slots per symbol
                                    div_req.start    = 1'b1;
                                    div_req.dividend = DIV_DVD_W'(FFT_SIZE)
                                                       << (DIV_DVD_W - FFT_W);
                                    div_req.divisor  = spc_reg;
                                    div_req.steps    = DIV_CNT_W'(FFT_W);
                                    job_next         = JOB_DEN;
                                    st_next          = ST_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    case (job_reg)
                        JOB_DEN:
                        begin
                            denom_next = FFT_W'(FFT_SIZE) - div_rsp.quotient[FFT_W-1:0];
                            st_next    = ST_MUL;
                        end
                        JOB_TOT:
                        begin
                            total_next = tot_sat;
                            phase_next = tot_sat != '0;
                            st_next    = ST_EMIT;
                        end
                        JOB_RE:
                        begin
                            re_q_next        = q_signed;
                            div_req.start    = 1'b1;
                            div_req.dividend = DIV_DVD_W'({im_mag, NORM_FRAC'(0)})
                                               << (DIV_DVD_W - MAG_W);
                            div_req.divisor  = DIV_DVS_W'(norm_div);
                            div_req.steps    = DIV_CNT_W'(MAG_W);
                            job_next         = JOB_IM;
                        end
                        JOB_IM:
                        begin
                            emit_word_next = (WORD_W'(re_q_reg) << 32) | WORD_W'(q_signed);
                            st_next        = ST_EMIT;
                        end
                        default: st_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod;
                div_req.divisor  = DIV_DVS_W'(denom_reg);
                div_req.steps    = DIV_CNT_W'(DIV_DVD_W);
                job_next         = JOB_TOT;
                st_next          = ST_DIV;
            end
            ST_EMIT, ST_PILOT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = (st_reg == ST_EMIT) ? emit_word_reg : pilot_word;
                    out_last_next  = !more;
                    slot_next      = slot_aft;
                    pcnt_next      = pcnt_aft;
                    sym_next       = sym_aft;
                    phase_next     = phase_aft;
                    pilot_cnt_next = st_reg == ST_PILOT;
                    st_next        = more ? ST_PILOT : ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            job_reg       <= JOB_DEN;
            phase_reg     <= 1'b0;
            len_reg       <= '0;
            nsym_reg      <= '0;
            spc_reg       <= '0;
            total_reg     <= '0;
            sym_reg       <= '0;
            slot_reg      <= '0;
            pcnt_reg      <= '0;
            emit_adv_reg  <= 1'b0;
            pilot_cnt_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            job_reg       <= job_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            nsym_reg      <= nsym_next;
            spc_reg       <= spc_next;
            total_reg     <= total_next;
            sym_reg       <= sym_next;
            slot_reg      <= slot_next;
            pcnt_reg      <= pcnt_next;
            emit_adv_reg  <= emit_adv_next;
            pilot_cnt_reg <= pilot_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        denom_reg     <= denom_next;
        word_reg      <= word_next;
        emit_word_reg <= emit_word_next;
        re_q_reg      <= re_q_next;
        out_word_reg  <= out_word_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_word    = out_word_reg;
    assign last_of_run = out_last_reg;

    a_phase_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> spc_reg >= 32'd2)
        else $error("data phase with pilot spacing below two");

    a_symbol_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> sym_reg < total_reg)
        else $error("symbol index past symbol total in data phase");

    a_pilot_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> 32'(pcnt_reg) < spc_reg)
        else $error("pilot phase counter not below spacing");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== tb/ofdm_pilot_insertion_top_tb.sv =====
// self-checking testbench for ofdm_pilot_insertion_top: parameter phase, data phase, registers
// depends on opi_pkg and the rtl of the block; an inline predictor builds the expected words
`timescale 1ns / 1ps

module ofdm_pilot_insertion_top_tb;
    import opi_pkg::*;

    localparam int FFT_N        = FFT_SIZE_DEF;
    localparam int FRAC_W       = SAMPLE_WIDTH_DEF - SAMPLE_INT_BITS_DEF;
    localparam int MOD_LSB      = PARAM_ID_BITS_DEF + PARAM_VAL_BITS_DEF;
    localparam int MAX_PER_ITEM = 3;
    localparam int SETTLE_CYC   = 150;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } ofdm_out_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [WORD_W-1:0]     in_word   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [WORD_W-1:0]     out_word;
    logic                  last_of_run;

    // predictor copy of registers and sequencing state
    logic [1:0]  pilot_re_r = PILOT_RE_RST;
    logic [1:0]  pilot_im_r = PILOT_IM_RST;
    logic [15:0] norm_r     = NORM_RST;
    bit          in_data    = 1'b0;
    logic [31:0] data_len   = '0;
    logic [31:0] sym_count  = '0;
    logic [31:0] spacing    = '0;
    logic [31:0] sym_total  = '0;
    logic [31:0] sym_idx    = '0;
    int unsigned slot_idx   = 0;

    logic [WORD_W-1:0] step_words[$];
    ofdm_out_t         ofdm_out_q[$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  samples_sent   = 0;
    int  data_phases    = 0;
    int  config_writes  = 0;
    bit  gaps_on        = 1'b0;
    bit  stall_on       = 1'b0;
    int  hold_request   = 0;
    int  hold_left      = 0;
    int  stall_run      = 0;

    ofdm_pilot_insertion_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .last_of_run(last_of_run)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [15:0] normalize_part(logic [15:0] raw);
        longint num;
        longint quot;
        if (norm_r == 16'd0)
            return 16'd0;
        num  = longint'($signed(raw)) * 4096;
        quot = num / longint'({48'd0, norm_r});
        return quot[15:0];
    endfunction

    function automatic void step_slot();
        slot_idx++;
        if (slot_idx >= FFT_N)
        begin
            slot_idx = 0;
            sym_idx++;
            if (sym_idx >= sym_total)
                in_data = 1'b0;
        end
    endfunction

    function automatic void add_pilots();
        while (in_data && step_words.size() < MAX_PER_ITEM && spacing != 0 &&
               (slot_idx % spacing) == 0)
        begin
            step_words.push_back({16'h0, pilot_re_r, {FRAC_W{1'b0}},
                                  16'h0, pilot_im_r, {FRAC_W{1'b0}}});
            step_slot();
        end
    endfunction

    function automatic void insert_pilots_for(logic [WORD_W-1:0] w);
        logic [WORD_W-MOD_LSB-1:0] mod_id;
        logic [7:0]                pid;
        logic [31:0]               val;
        logic [31:0]               denom;
        logic [63:0]               prod;
        logic [63:0]               quot;
        mod_id = w[WORD_W-1:MOD_LSB];
        pid    = w[MOD_LSB-1:PARAM_VAL_BITS_DEF];
        val    = w[31:0];
        step_words.delete();
        if (!in_data)
        begin
            if (mod_id == MODULE_SELF)
            begin
                if (pid == PID_LEN)
                    data_len = val;
                else if (pid == PID_SYM)
                    sym_count = val;
                else if (pid == PID_SPC)
                    spacing = val;
                return;
            end
            step_words.push_back(w);
            if (mod_id == '1)
            begin
                sym_total = '0;
                sym_idx   = '0;
                slot_idx  = 0;
                if (spacing >= 2)
                begin
                    denom     = FFT_N - FFT_N / spacing;
                    prod      = {32'd0, data_len} * {32'd0, sym_count};
                    quot      = prod / denom;
                    sym_total = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
                    in_data   = (sym_total != 0);
                    add_pilots();
                end
            end
        end
        else
        begin
            step_words.push_back({16'h0, normalize_part(w[47:32]),
                                  16'h0, normalize_part(w[15:0])});
            step_slot();
            add_pilots();
        end
        foreach (step_words[i])
            ofdm_out_q.push_back('{word: step_words[i], last: (i == step_words.size() - 1)});
    endfunction

    // ---------------------------------------------------------------- output side

    always @(posedge clk)
    begin
        ofdm_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (ofdm_out_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected transaction expected none actual out_word=%h last=%b",
                         $time, out_word, last_of_run);
            end
            else
            begin
                want = ofdm_out_q.pop_front();
                if (out_word !== want.word)
                begin
                    mismatch_count++;
                    $display("%0t ns: out_word expected %h actual %h",
                             $time, want.word, out_word);
                end
                if (last_of_run !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t ns: last_of_run expected %b actual %b (out_word %h)",
                             $time, want.last, last_of_run, out_word);
                end
            end
        end
    end

    // receiver: random short stalls, rare long ones, and the requested long hold-off
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!stall_on)
            out_stall <= 1'b0;
        else if (stall_run > 0)
        begin
            stall_run--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            stall_run = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                     : $urandom_range(8, 40);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ---------------------------------------------------------------- input side

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WORD_W-1:0] param_word(int pid, logic [31:0] val);
        return {24'(MODULE_SELF), 8'(pid), val};
    endfunction

    function automatic logic [WORD_W-1:0] term_word();
        return {24'hFF_FFFF, 8'($urandom), 32'($urandom)};
    endfunction

    // valid stays high across back-to-back transactions
    task automatic send_word(input logic [WORD_W-1:0] w);
        int gap;
        gap = 0;
        if (gaps_on)
        begin
            if ($urandom_range(0, 99) >= 92)
                gap = $urandom_range(6, 30);
            else if ($urandom_range(0, 99) >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        insert_pilots_for(w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ofdm_out_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PILOT_RE: pilot_re_r = val[1:0];
            REG_PILOT_IM: pilot_im_r = val[1:0];
            REG_NORM:     norm_r     = val[15:0];
            default:      ;
        endcase
    endtask

    // parameter words cause no output, so give the block time after the last result
    task automatic set_config(input logic [31:0] re, input logic [31:0] im,
                              input logic [31:0] norm);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        reg_write(REG_PILOT_RE, re);
        reg_write(REG_PILOT_IM, im);
        reg_write(REG_NORM, norm);
        config_writes++;
    endtask

    // one well-formed parameter sequence with some noise ahead, then samples to the end
    task automatic run_phase(input logic [31:0] spc, input int n_sym, input bit pressure);
        logic [31:0] denom;
        logic [31:0] len;
        logic [31:0] a;
        logic [31:0] b;
        int          k;
        denom    = FFT_N - FFT_N / spc;
        len      = denom * n_sym + $urandom_range(0, denom - 1);
        gaps_on  = !pressure && ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 3))
                0: send_word({24'($urandom_range(4, 24'hFF_FFFE)), 8'($urandom), 32'($urandom)});
                1: send_word({24'($urandom_range(0, 2)), 8'($urandom), 32'($urandom)});
                2: send_word(param_word($urandom_range(3, 255), $urandom));
                default:
                begin
                    // broken run: spacing too small, terminator only forwarded
                    send_word(param_word(PID_SPC, $urandom_range(0, 1)));
                    send_word(term_word());
                end
            endcase
        end
        if ($urandom_range(0, 1) != 0)
        begin
            a = len;
            b = 1;
        end
        else
        begin
            a = 1;
            b = len;
        end
        if ($urandom_range(0, 1) != 0)
        begin
            send_word(param_word(PID_LEN, a));
            send_word(param_word(PID_SYM, b));
            send_word(param_word(PID_SPC, spc));
        end
        else
        begin
            send_word(param_word(PID_SPC, spc));
            send_word(param_word(PID_SYM, b));
            send_word(param_word(PID_LEN, a));
        end
        send_word(term_word());
        k = 0;
        while (in_data)
        begin
            if (pressure && k == 8)
                hold_request = LONG_HOLD;
            if (pressure && k == 30)
                wait_drained();
            else if (!pressure && $urandom_range(0, 63) == 0)
                wait_drained();
            send_word(rand_word());
            k++;
            samples_sent++;
        end
        data_phases++;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_param_phase();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        send_word(64'h0);
        send_word(64'hFFFF_FEFF_FFFF_FFFF);
        send_word({24'd2, 40'hFF_FFFF_FFFF});
        send_word({24'd4, 40'h00_0000_0001});
        send_word(param_word(3, 32'hFFFF_FFFF));       // cyclic prefix id, dropped
        send_word(param_word(8'hFF, 32'h1234_5678));   // unknown id, dropped
        send_word(term_word());                        // spacing still zero from reset
        send_word(param_word(PID_SPC, 1));
        send_word(param_word(PID_LEN, 32'hFFFF_FFFF));
        send_word(param_word(PID_SYM, 32'hFFFF_FFFF));
        send_word(term_word());                        // spacing below two
        send_word(param_word(PID_SPC, 2));
        send_word(param_word(PID_LEN, 0));
        send_word(term_word());                        // zero symbols
    endtask

    // reset pilot and divisor values, two symbols so pilots wrap into the next one
    task automatic test_first_phase();
        logic [WORD_W-1:0] edge_samples[5];
        edge_samples = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                         {16'h0, 16'h7FFF, 16'h0, 16'h8000},
                         {16'hFFFF, 16'h8000, 16'hFFFF, 16'h7FFF},
                         {16'h0, 16'h0001, 16'h0, 16'hFFFF}};
        send_word(param_word(PID_SPC, 2));
        send_word(param_word(PID_LEN, 64));
        send_word(param_word(PID_SYM, 1));
        send_word(term_word());
        foreach (edge_samples[i])
        begin
            send_word(edge_samples[i]);
            samples_sent++;
        end
        while (in_data)
        begin
            send_word(rand_word());
            samples_sent++;
        end
        data_phases++;
    endtask

    // spacing 3 over two symbols gives a sample followed by two pilots
    task automatic test_backpressure();
        set_config(32'h1, 32'hFFFF_FFFF, {16'h0, NORM_RST});
        run_phase(3, 2, 1'b1);
    endtask

    task automatic test_random_runs();
        logic [31:0] cfg_tab[4][3];
        logic [31:0] spc;
        int          n_sym;
        int          idx;
        cfg_tab = '{'{32'hFFFF_FFFE, 32'h1, 32'd1},
                    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd65535},
                    '{32'h1, 32'hFFFF_FFFF, 32'd0},           // zero divisor
                    '{32'h0, 32'h0, 32'd4096}};
        idx = 0;
        while (samples_sent < 260 || idx < 4)
        begin
            if (idx < 4)
                set_config(cfg_tab[idx][0], cfg_tab[idx][1], cfg_tab[idx][2]);
            else if ($urandom_range(0, 1) != 0)
                set_config($urandom, $urandom, $urandom_range(1, 65535));
            case ($urandom_range(0, 9))
                0:       spc = 2;
                1:       spc = 3;
                2:       spc = 4;
                3:       spc = 5;
                4:       spc = 7;
                5:       spc = 8;
                6:       spc = 16;
                7:       spc = 64;
                8:       spc = $urandom_range(65, 1000);
                default: spc = 32'hFFFF_FFFF;
            endcase
            n_sym = (spc <= 3 && $urandom_range(0, 3) == 0) ? 2 : 1;
            run_phase(spc, n_sym, 1'b0);
            idx++;
        end
    endtask

    // product overflows the symbol count, so the block stays in the data phase
    task automatic test_oversized_product();
        set_config(32'h1, 32'h0, $urandom_range(1, 65535));
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        send_word(param_word(PID_LEN, 32'hFFFF_FFFF));
        send_word(param_word(PID_SYM, 32'hFFFF_FFFF));
        send_word(param_word(PID_SPC, 2));
        send_word(term_word());
        repeat (40)
        begin
            send_word(rand_word());
            samples_sent++;
        end
        data_phases++;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_param_phase();
        test_first_phase();
        test_backpressure();
        test_random_runs();
        test_oversized_product();

        wait_drained();
        repeat (200) @(posedge clk);

        $display("covered %0d samples over %0d data phases and %0d register settings",
                 samples_sent, data_phases, config_writes);
        $display("checked %0d output transactions, %0d mismatches",
                 results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== ofdm_pilot_insertion_top.f =====
design/opi_pkg.sv
design/opi_front.sv
design/opi_queue.sv
design/opi_divider.sv
design/opi_back.sv
design/ofdm_pilot_insertion_top.sv
tb/ofdm_pilot_insertion_top_tb.sv
